// ===== hdl/dual_pid_follow_controller_unit_assert.svh =====
// Assertion macros for the dual PID follow controller.
// Used by the lane and the top level; expects a clk and rst in scope.
`ifndef DUAL_PID_FOLLOW_CONTROLLER_UNIT_ASSERT_SVH
`define DUAL_PID_FOLLOW_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DPF_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPF_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== hdl/dpf_pkg.sv =====
// Shared types and constants for the dual PID follow controller.
// No dependencies; imported by every module of the block.
package dpf_pkg;

  localparam int ANGULAR_LIMIT_DEF = 4096;
  localparam int LINEAR_LIMIT_DEF  = 3277;
  localparam int BACKWARD_GAIN_DEF = 8192;
  localparam int FRAC_BITS_DEF     = 12;

  localparam int ERR_W     = 16;
  localparam int MS_W      = 16;
  localparam int NUM_W     = 33;
  localparam int DIV_STEPS = 32;
  localparam int DERIV_W   = 28;
  localparam int SUM_W     = 50;

  localparam logic [2:0] REG_TARGET_ANGLE    = 3'd0;
  localparam logic [2:0] REG_TARGET_DISTANCE = 3'd1;
  localparam logic [2:0] REG_ANGLE_KP        = 3'd2;
  localparam logic [2:0] REG_ANGLE_KI        = 3'd3;
  localparam logic [2:0] REG_ANGLE_KD        = 3'd4;
  localparam logic [2:0] REG_DIST_KP         = 3'd5;
  localparam logic [2:0] REG_DIST_KI         = 3'd6;
  localparam logic [2:0] REG_DIST_KD         = 3'd7;

  localparam logic signed [15:0] TARGET_ANGLE_RST    = 16'sd0;
  localparam logic [14:0]        TARGET_DISTANCE_RST = 15'd4096;
  localparam logic signed [15:0] ANGLE_KP_RST        = 16'sd10240;
  localparam logic signed [15:0] DIST_KP_RST         = 16'sd3277;

  typedef struct packed {
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
  } gains_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] drive;
  } lane_res_t;

endpackage

// ===== hdl/dpf_div.sv =====
// Bit-serial floor divider: signed numerator by a positive divisor.
// Depends on dpf_pkg; one quotient bit per cycle.
module dpf_div
  import dpf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [MS_W-1:0]         den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy;
  logic             fin;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      work;
  logic [MS_W:0]    rem;
  logic [MS_W:0]    trial;
  logic             ge;
  logic [MS_W:0]    rem_step;
  logic [31:0]      mag_in;
  logic [NUM_W-1:0] neg_num;

  assign neg_num  = -num;
  assign mag_in   = num[NUM_W-1] ? neg_num[31:0] : num[31:0];
  assign trial    = {rem[MS_W-1:0], work[31]};
  assign ge       = trial >= {1'b0, den};
  assign rem_step = ge ? trial - {1'b0, den} : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        work <= mag_in;
        rem  <= '0;
        neg  <= num[NUM_W-1];
      end else if (busy) begin
        rem  <= rem_step;
        work <= {work[30:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        // A nonzero remainder on a negative quotient rounds one further down.
        if (neg) begin
          quo <= -($signed(NUM_W'(work)) + $signed(NUM_W'(rem != '0)));
        end else begin
          quo <= $signed(NUM_W'(work));
        end
      end
    end
  end

endmodule

// ===== hdl/dpf_lane.sv =====
// One PID lane: integral, derivative and limited drive for one error.
// Depends on dpf_pkg, dpf_div and the assertion macro header.
`include "dual_pid_follow_controller_unit_assert.svh"
module dpf_lane
  import dpf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int INT_CAP   = 4096,
  parameter int LIMIT     = ANGULAR_LIMIT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ERR_W-1:0] err,
  input  logic [MS_W-1:0]         ms,
  input  gains_t                  gains,
  output lane_res_t               res
);

  typedef enum logic [2:0] {S_IDLE, S_DIVGO, S_DIV, S_MUL, S_SUM, S_OUT} state_t;

  localparam logic signed [33:0] IntMin = -(34'sd1 <<< 31);
  localparam logic signed [33:0] IntCap = 34'(INT_CAP);
  localparam logic signed [SUM_W-1:0] LimHi = SUM_W'(LIMIT);
  localparam logic signed [SUM_W-1:0] LimLo = -SUM_W'(LIMIT);
  // Rounded-up 2^38 / 1000; exact for every 32-bit numerator.
  localparam logic [28:0] Recip1000 = 29'd274877907;

  state_t                    state;
  logic signed [31:0]        integ;
  logic signed [ERR_W-1:0]   prev;
  logic signed [ERR_W-1:0]   e_r;
  logic signed [NUM_W-1:0]   num_i;
  logic signed [NUM_W-1:0]   num_d;
  logic signed [DERIV_W-1:0] d_r;
  logic signed [31:0]        p_kp;
  logic signed [47:0]        p_ki;
  logic signed [43:0]        p_kd;
  logic signed [SUM_W-1:0]   total;
  logic signed [SUM_W-1:0]   scaled;

  logic                      div_start;
  logic                      done_d;
  logic signed [NUM_W-1:0]   q_i;
  logic signed [NUM_W-1:0]   q_d;
  logic signed [33:0]        integ_sum;
  logic signed [31:0]        integ_next;
  logic signed [16:0]        diff;

  logic                      ineg;
  logic [31:0]               imag;
  logic [60:0]               iprod;
  logic [22:0]               iq_mag;
  logic [31:0]               irem;
  logic signed [NUM_W-1:0]   neg_num_i;

  assign div_start = (state == S_DIVGO);
  assign diff      = 17'(err) - 17'(prev);
  assign integ_sum = 34'(integ) + 34'(q_i);
  assign scaled    = total >>> FRAC_BITS;
  assign neg_num_i = -num_i;
  assign iq_mag    = iprod[60:38];
  assign irem      = imag - 32'(iq_mag) * 32'd1000;

  always_comb begin
    if (integ_sum > IntCap) begin
      integ_next = 32'(IntCap);
    end else if (integ_sum < IntMin) begin
      integ_next = 32'(IntMin);
    end else begin
      integ_next = integ_sum[31:0];
    end
  end

  // The integral step divides by 1000 through a reciprocal multiply; the result
  // passes iprod and then q_i after imag loads, well before the divider finishes.
  always_ff @(posedge clk) begin
    iprod <= 61'(imag) * 61'(Recip1000);
    if (ineg) begin
      q_i <= -(NUM_W'(iq_mag) + NUM_W'(irem != '0));
    end else begin
      q_i <= NUM_W'(iq_mag);
    end
  end

  dpf_div u_div_der (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_d),
    .den   (ms),
    .done  (done_d),
    .quo   (q_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      integ    <= '0;
      prev     <= '0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            e_r   <= err;
            num_i <= NUM_W'(err) * $signed({17'b0, ms});
            num_d <= NUM_W'(diff) * NUM_W'(1000);
            state <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          ineg  <= num_i[NUM_W-1];
          imag  <= num_i[NUM_W-1] ? neg_num_i[31:0] : num_i[31:0];
          state <= S_DIV;
        end
        S_DIV: begin
          if (done_d) begin
            integ <= integ_next;
            prev  <= e_r;
            d_r   <= q_d[DERIV_W-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p_kp  <= 32'(gains.kp) * 32'(e_r);
          p_ki  <= 48'(gains.ki) * 48'(integ);
          p_kd  <= 44'(gains.kd) * 44'(d_r);
          state <= S_SUM;
        end
        S_SUM: begin
          total <= SUM_W'(p_kp) + SUM_W'(p_ki) + SUM_W'(p_kd);
          state <= S_OUT;
        end
        S_OUT: begin
          if (scaled > LimHi) begin
            res.drive <= 16'(LimHi);
          end else if (scaled < LimLo) begin
            res.drive <= 16'(LimLo);
          end else begin
            res.drive <= scaled[15:0];
          end
          res.done <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DPF_ASSERT_NOW(a_integ_cap, 1'b1, 34'(integ) <= IntCap, "integral above cap")
  `DPF_ASSERT_NOW(a_start_idle, start, state == S_IDLE, "lane started while busy")
  `DPF_ASSERT_NOW(a_drive_lim, res.done,
    (SUM_W'(res.drive) <= LimHi) && (SUM_W'(res.drive) >= LimLo), "drive beyond limit")

endmodule

// ===== hdl/dual_pid_follow_controller_unit.sv =====
// Top level of the dual PID follow controller: registers, error forming, merge.
// Depends on dpf_pkg, dpf_lane and the assertion macro header.
//
// The two lanes (angle and distance) run side by side; each computes its
// derivative with a bit-serial divider that loads its operands, forms the
// quotient bit by bit and then rounds, while the integral's division by
// 1000 is a reciprocal multiply that finishes in the divider's shadow. The
// rest is error forming, multiply, sum, limit and merge. A new request is taken
// as soon as the previous result has moved into the output register, where it
// may still wait for the consumer; a later result then waits in the merge step
// until that register is free. Configuration is written over the APB-style port
// at byte address 4*i; the user must write it only while no request is in
// flight, and the block itself does not enforce this.
`include "dual_pid_follow_controller_unit_assert.svh"
module dual_pid_follow_controller_unit
  import dpf_pkg::*;
#(
  parameter int ANGULAR_LIMIT = ANGULAR_LIMIT_DEF,
  parameter int LINEAR_LIMIT  = LINEAR_LIMIT_DEF,
  parameter int BACKWARD_GAIN = BACKWARD_GAIN_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] bearing,
  input  logic [14:0]        range_m,
  input  logic [15:0]        elapsed_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [13:0] angular_speed,
  output logic signed [12:0] lin_speed,
  output logic               publish
);

  localparam int AngleDb   = ((1 << FRAC_BITS) + 5) / 10;
  localparam int DistDb    = ((2 << FRAC_BITS) + 5) / 10;
  localparam int AngleCap  = ((8 << FRAC_BITS) + 5) / 10;
  localparam int DistCap   = 5 << FRAC_BITS;
  localparam int MinRange  = ((6 << FRAC_BITS) + 5) / 10;
  localparam int Creep     = ((2 << FRAC_BITS) + 5) / 10;
  localparam int Still     = ((1 << FRAC_BITS) + 500) / 1000;

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_RUN, S_MERGE} state_t;

  state_t             state;
  logic signed [15:0] target_angle;
  logic [14:0]        target_distance;
  gains_t             angle_gains;
  gains_t             dist_gains;

  logic signed [15:0] bearing_r;
  logic [14:0]        range_r;
  logic [15:0]        ms_r;
  logic signed [15:0] err_a;
  logic signed [15:0] err_d;
  logic               lane_go;
  logic signed [15:0] ang_r;
  logic signed [15:0] lin_r;
  logic signed [15:0] last_lin;

  lane_res_t          a_res;
  lane_res_t          d_res;

  logic               wr_en;
  logic [2:0]         reg_idx;
  logic signed [16:0] ea17;
  logic signed [15:0] ea_next;
  logic signed [15:0] ed16;
  logic signed [15:0] ed_db;
  logic signed [31:0] bprod;
  logic signed [31:0] bscaled;
  logic signed [15:0] ed_next;
  logic signed [15:0] lin_merged;
  logic               out_free;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = paddr[4:2];
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    unique case (reg_idx)
      REG_TARGET_ANGLE:    prdata = 32'(target_angle);
      REG_TARGET_DISTANCE: prdata = {17'b0, target_distance};
      REG_ANGLE_KP:        prdata = 32'(angle_gains.kp);
      REG_ANGLE_KI:        prdata = 32'(angle_gains.ki);
      REG_ANGLE_KD:        prdata = 32'(angle_gains.kd);
      REG_DIST_KP:         prdata = 32'(dist_gains.kp);
      REG_DIST_KI:         prdata = 32'(dist_gains.ki);
      REG_DIST_KD:         prdata = 32'(dist_gains.kd);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle    <= TARGET_ANGLE_RST;
      target_distance <= TARGET_DISTANCE_RST;
      angle_gains     <= '{kp: ANGLE_KP_RST, ki: 16'sd0, kd: 16'sd0};
      dist_gains      <= '{kp: DIST_KP_RST, ki: 16'sd0, kd: 16'sd0};
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET_ANGLE:    target_angle    <= pwdata[15:0];
        REG_TARGET_DISTANCE: target_distance <= pwdata[14:0];
        REG_ANGLE_KP:        angle_gains.kp  <= pwdata[15:0];
        REG_ANGLE_KI:        angle_gains.ki  <= pwdata[15:0];
        REG_ANGLE_KD:        angle_gains.kd  <= pwdata[15:0];
        REG_DIST_KP:         dist_gains.kp   <= pwdata[15:0];
        REG_DIST_KI:         dist_gains.ki   <= pwdata[15:0];
        REG_DIST_KD:         dist_gains.kd   <= pwdata[15:0];
        default:             target_angle    <= target_angle;
      endcase
    end
  end

  // Error forming: deadband, backward gain on a negative distance error, saturation.
  always_comb begin
    ea17 = 17'(bearing_r) - 17'(target_angle);
    if (ea17 > -17'(AngleDb) && ea17 < 17'(AngleDb)) begin
      ea17 = '0;
    end
    if (ea17 > 17'sd32767) begin
      ea_next = 16'sd32767;
    end else if (ea17 < -17'sd32768) begin
      ea_next = -16'sd32768;
    end else begin
      ea_next = ea17[15:0];
    end

    ed16 = $signed({1'b0, range_r}) - $signed({1'b0, target_distance});
    ed_db = (ed16 > -16'(DistDb) && ed16 < 16'(DistDb)) ? 16'sd0 : ed16;
    bprod   = 32'(ed_db) * 32'(BACKWARD_GAIN);
    bscaled = bprod >>> FRAC_BITS;
    if (ed_db >= 0) begin
      ed_next = ed_db;
    end else if (bscaled < -32'sd32768) begin
      ed_next = -16'sd32768;
    end else begin
      ed_next = bscaled[15:0];
    end
  end

  // Creep while turning: a still linear drive takes the sign of the last one.
  always_comb begin
    lin_merged = lin_r;
    if (lin_r > -16'(Still) && lin_r < 16'(Still) && ang_r != 0) begin
      if (last_lin > 0) begin
        lin_merged = 16'(Creep);
      end else if (last_lin < 0) begin
        lin_merged = -16'(Creep);
      end
    end
  end

  dpf_lane #(
    .FRAC_BITS (FRAC_BITS),
    .INT_CAP   (AngleCap),
    .LIMIT     (ANGULAR_LIMIT)
  ) u_lane_angle (
    .clk   (clk),
    .rst   (rst),
    .start (lane_go),
    .err   (err_a),
    .ms    (ms_r),
    .gains (angle_gains),
    .res   (a_res)
  );

  dpf_lane #(
    .FRAC_BITS (FRAC_BITS),
    .INT_CAP   (DistCap),
    .LIMIT     (LINEAR_LIMIT)
  ) u_lane_dist (
    .clk   (clk),
    .rst   (rst),
    .start (lane_go),
    .err   (err_d),
    .ms    (ms_r),
    .gains (dist_gains),
    .res   (d_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lane_go   <= 1'b0;
      out_valid <= 1'b0;
      last_lin  <= '0;
    end else begin
      lane_go <= 1'b0;
      if (out_valid && out_ready && state != S_MERGE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            bearing_r <= bearing;
            range_r   <= range_m;
            ms_r      <= (elapsed_ms == '0) ? 16'd1 : elapsed_ms;
            state     <= S_PREP;
          end
        end
        S_PREP: begin
          err_a   <= ea_next;
          err_d   <= ed_next;
          lane_go <= 1'b1;
          state   <= S_RUN;
        end
        S_RUN: begin
          if (a_res.done) begin
            ang_r <= a_res.drive;
            lin_r <= d_res.drive;
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (16'(range_r) < 16'(MinRange)) begin
              angular_speed <= '0;
              lin_speed     <= '0;
              publish       <= 1'b0;
            end else begin
              angular_speed <= ang_r[13:0];
              lin_speed     <= lin_merged[12:0];
              publish       <= 1'b1;
              last_lin      <= lin_merged;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DPF_ASSERT_NEXT(a_accept_prep, in_valid && in_ready, state == S_PREP,
    "accepted request did not enter error forming")
  `DPF_ASSERT_NOW(a_lanes_lockstep, 1'b1, a_res.done == d_res.done, "lanes out of step")
  `DPF_ASSERT_NOW(a_silent_zero, out_valid && !publish,
    angular_speed == 0 && lin_speed == 0, "unpublished result carries drive")

endmodule
